>>> hw/rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

   localparam int LIMIT_W = 7;
   localparam int EXT_HANDLE_W = 16;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

   localparam logic FUNC_ENQ = 1'b0;
   localparam logic FUNC_DEQ = 1'b1;

   localparam logic [1:0] STATUS_ENQ = 2'd0;
   localparam logic [1:0] STATUS_DROP = 2'd1;
   localparam logic [1:0] STATUS_DEQ = 2'd2;
   localparam logic [1:0] STATUS_EMPTY = 2'd3;

   localparam logic [1:0] CLS_LOW = 2'd0;
   localparam logic [1:0] CLS_HIGH = 2'd1;
   localparam logic [1:0] CLS_VERY_HIGH = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage

`default_nettype wire

>>> hw/rtl/spq_ram.sv
`default_nettype none

module spq_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/spq_ctrl.sv
`default_nettype none

module spq_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   output logic                 rsp_valid,
   output spq_pkg::cmd_type     cmd
);

   spq_pkg::state_type state_ff;
   spq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         spq_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = spq_pkg::ST_EXEC;
            end
         end
         spq_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = spq_pkg::ST_RESP;
         end
         spq_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            state_in = spq_pkg::ST_IDLE;
         end
         default: begin
            state_in = spq_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hw/rtl/spq_dpath.sv
`default_nettype none

module spq_dpath #(
   parameter int DEPTH = 64,
   parameter int HANDLE_WIDTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire spq_pkg::cmd_type                  cmd,
   input  wire logic                              req_func,
   input  wire logic [spq_pkg::EXT_HANDLE_W-1:0]  req_packet_handle,
   input  wire logic                              req_very_high_flag,
   input  wire logic                              req_high_flag,
   input  wire logic                              csr_wr_en,
   input  wire logic [spq_pkg::LIMIT_W-1:0]       csr_wr_data,
   output logic      [1:0]                        rsp_status,
   output logic      [spq_pkg::EXT_HANDLE_W-1:0]  rsp_out_handle,
   output logic      [1:0]                        rsp_out_class
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > spq_pkg::LIMIT_W) ? CNT_W : spq_pkg::LIMIT_W;
   localparam int NCLASS = 3;
   localparam logic [spq_pkg::EXT_HANDLE_W-1:0] HANDLE_MASK =
      (HANDLE_WIDTH >= spq_pkg::EXT_HANDLE_W) ? '1 :
      spq_pkg::EXT_HANDLE_W'((17'd1 << HANDLE_WIDTH) - 17'd1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic                               func_ff;
   logic [spq_pkg::EXT_HANDLE_W-1:0]   handle_ff;
   logic [1:0]                         cls_ff;
   logic [spq_pkg::LIMIT_W-1:0]        limit_ff;
   logic [PTR_W-1:0]                   head_ff [NCLASS];
   logic [PTR_W-1:0]                   head_in [NCLASS];
   logic [PTR_W-1:0]                   tail_ff [NCLASS];
   logic [PTR_W-1:0]                   tail_in [NCLASS];
   logic [CNT_W-1:0]                   cnt_ff [NCLASS];
   logic [CNT_W-1:0]                   cnt_in [NCLASS];
   logic [1:0]                         status_ff;
   logic [1:0]                         status_in;
   logic [1:0]                         class_ff;
   logic [1:0]                         class_in;
   logic [spq_pkg::EXT_HANDLE_W-1:0]   out_handle_ff;
   logic [spq_pkg::EXT_HANDLE_W-1:0]   out_handle_in;
   logic [HANDLE_WIDTH-1:0]            rd_data [NCLASS];
   logic [NCLASS-1:0]                  wr_en;
   logic [NCLASS-1:0]                  rd_en;
   logic [1:0]                         deq_cls;
   logic                               any_full;
   logic                               drop;
   logic [CNT_W-1:0]                   enq_cnt;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         handle_ff <= req_packet_handle & HANDLE_MASK;
         priority if (req_very_high_flag) begin
            cls_ff <= spq_pkg::CLS_VERY_HIGH;
         end else if (req_high_flag) begin
            cls_ff <= spq_pkg::CLS_HIGH;
         end else begin
            cls_ff <= spq_pkg::CLS_LOW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= spq_pkg::LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   always_comb begin
      enq_cnt = cnt_ff[cls_ff];
      drop = (CMP_W'(enq_cnt) >= CMP_W'(limit_ff)) || (enq_cnt >= CNT_FULL);
      any_full = 1'b1;
      deq_cls = spq_pkg::CLS_LOW;
      priority if (cnt_ff[spq_pkg::CLS_VERY_HIGH] != '0) begin
         deq_cls = spq_pkg::CLS_VERY_HIGH;
      end else if (cnt_ff[spq_pkg::CLS_HIGH] != '0) begin
         deq_cls = spq_pkg::CLS_HIGH;
      end else if (cnt_ff[spq_pkg::CLS_LOW] != '0) begin
         deq_cls = spq_pkg::CLS_LOW;
      end else begin
         any_full = 1'b0;
      end
   end

   always_comb begin
      for (int c = 0; c < NCLASS; c++) begin
         head_in[c] = head_ff[c];
         tail_in[c] = tail_ff[c];
         cnt_in[c] = cnt_ff[c];
         wr_en[c] = 1'b0;
         rd_en[c] = 1'b0;
      end
      status_in = status_ff;
      class_in = class_ff;
      out_handle_in = out_handle_ff;
      if (cmd.exec) begin
         if (func_ff == spq_pkg::FUNC_ENQ) begin
            class_in = cls_ff;
            out_handle_in = handle_ff;
            if (drop) begin
               status_in = spq_pkg::STATUS_DROP;
            end else begin
               status_in = spq_pkg::STATUS_ENQ;
               wr_en[cls_ff] = 1'b1;
               tail_in[cls_ff] = (tail_ff[cls_ff] == PTR_LAST) ? '0 :
                                 tail_ff[cls_ff] + 1'b1;
               cnt_in[cls_ff] = enq_cnt + 1'b1;
            end
         end else if (any_full) begin
            status_in = spq_pkg::STATUS_DEQ;
            class_in = deq_cls;
            out_handle_in = '0;
            rd_en[deq_cls] = 1'b1;
            head_in[deq_cls] = (head_ff[deq_cls] == PTR_LAST) ? '0 :
                               head_ff[deq_cls] + 1'b1;
            cnt_in[deq_cls] = cnt_ff[deq_cls] - 1'b1;
         end else begin
            status_in = spq_pkg::STATUS_EMPTY;
            class_in = spq_pkg::CLS_LOW;
            out_handle_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NCLASS; c++) begin
            head_ff[c] <= '0;
            tail_ff[c] <= '0;
            cnt_ff[c] <= '0;
         end
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      class_ff <= class_in;
      out_handle_ff <= out_handle_in;
   end

   for (genvar c = 0; c < NCLASS; c++) begin : g_fifo
      spq_ram #(
         .DEPTH(DEPTH),
         .WIDTH(HANDLE_WIDTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en[c]),
         .wr_addr (tail_ff[c]),
         .wr_data (HANDLE_WIDTH'(handle_ff)),
         .rd_en   (rd_en[c]),
         .rd_addr (head_ff[c]),
         .rd_data (rd_data[c])
      );
   end

   assign rsp_status = status_ff;
   assign rsp_out_class = class_ff;
   assign rsp_out_handle = (status_ff == spq_pkg::STATUS_DEQ) ?
                           spq_pkg::EXT_HANDLE_W'(rd_data[class_ff]) : out_handle_ff;

endmodule

`default_nettype wire

>>> hw/rtl/strict_priority_queue_three_class.sv
// The FSM walks load, execute and respond (ST_IDLE, ST_EXEC, ST_RESP); a new
// item is taken only in ST_IDLE and its result strobe comes in ST_RESP. A
// dequeue uses the registered read port of the selected class FIFO.
// The receiver cannot stall; rsp_valid is high for exactly one cycle per item.
// Reset (synchronous, active high) clears pointers, counts and the FSM and sets
// queue_limit to 64; FIFO storage is not cleared.
`default_nettype none

module strict_priority_queue_three_class #(
   parameter int DEPTH = 64,
   parameter int HANDLE_WIDTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_func,
   input  wire logic [spq_pkg::EXT_HANDLE_W-1:0]  req_packet_handle,
   input  wire logic                              req_very_high_flag,
   input  wire logic                              req_high_flag,
   input  wire logic                              csr_wr_en,
   input  wire logic [spq_pkg::LIMIT_W-1:0]       csr_wr_data,
   output logic                                   rsp_valid,
   output logic      [1:0]                        rsp_status,
   output logic      [spq_pkg::EXT_HANDLE_W-1:0]  rsp_out_handle,
   output logic      [1:0]                        rsp_out_class
);

   spq_pkg::cmd_type cmd;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   spq_dpath #(
      .DEPTH        (DEPTH),
      .HANDLE_WIDTH (HANDLE_WIDTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_func           (req_func),
      .req_packet_handle  (req_packet_handle),
      .req_very_high_flag (req_very_high_flag),
      .req_high_flag      (req_high_flag),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_status         (rsp_status),
      .rsp_out_handle     (rsp_out_handle),
      .rsp_out_class      (rsp_out_class)
   );

endmodule

`default_nettype wire

>>> hw/rtl/spq_checker.sv
`default_nettype none

module spq_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              start,
   input wire logic                              busy,
   input wire logic                              rsp_valid,
   input wire logic [1:0]                        rsp_status,
   input wire logic [spq_pkg::EXT_HANDLE_W-1:0]  rsp_out_handle,
   input wire logic [1:0]                        rsp_out_class
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after item accepted");

   a_accept_resp: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##2 rsp_valid)
      else $error("no result two cycles after item accepted");

   a_resp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe longer than one cycle");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == spq_pkg::STATUS_EMPTY |->
         rsp_out_handle == '0 && rsp_out_class == spq_pkg::CLS_LOW)
      else $error("empty result carries nonzero handle or class");

   a_class_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_class == spq_pkg::CLS_LOW ||
         rsp_out_class == spq_pkg::CLS_HIGH || rsp_out_class == spq_pkg::CLS_VERY_HIGH)
      else $error("result class out of range");

endmodule

bind strict_priority_queue_three_class spq_checker u_spq_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_out_handle (rsp_out_handle),
   .rsp_out_class  (rsp_out_class)
);

`default_nettype wire

>>> sim/testbench.sv
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH = 64;
   localparam int CLASS_COUNT = 3;

   typedef struct packed {
      logic [1:0]                       status;
      logic [spq_pkg::EXT_HANDLE_W-1:0] handle;
      logic [1:0]                       cls;
   } queue_result_type;

   class queue_scoreboard;
      logic [spq_pkg::EXT_HANDLE_W-1:0] slot [CLASS_COUNT][QUEUE_DEPTH];
      int head [CLASS_COUNT];
      int tail [CLASS_COUNT];
      int fill [CLASS_COUNT];
      logic [spq_pkg::LIMIT_W-1:0] limit;
      queue_result_type pending_results [$];
      int failures;
      int items;
      int status_seen [4];

      function new();
         limit = spq_pkg::LIMIT_RESET;
         failures = 0;
         items = 0;
         for (int i = 0; i < CLASS_COUNT; i++) begin
            head[i] = 0;
            tail[i] = 0;
            fill[i] = 0;
         end
         for (int i = 0; i < 4; i++) status_seen[i] = 0;
      endfunction

      function void set_limit(logic [spq_pkg::LIMIT_W-1:0] value);
         limit = value;
      endfunction

      function void note_item(logic func, logic [spq_pkg::EXT_HANDLE_W-1:0] h,
                              logic vh, logic hi);
         queue_result_type r;
         logic [1:0] cls_code;
         int idx;
         r.status = spq_pkg::STATUS_EMPTY;
         r.handle = '0;
         r.cls = spq_pkg::CLS_LOW;
         items++;
         if (func == spq_pkg::FUNC_ENQ) begin
            cls_code = vh ? spq_pkg::CLS_VERY_HIGH :
                       (hi ? spq_pkg::CLS_HIGH : spq_pkg::CLS_LOW);
            idx = int'(cls_code);
            r.cls = cls_code;
            r.handle = h;
            if (fill[idx] >= int'(limit) || fill[idx] >= QUEUE_DEPTH) begin
               r.status = spq_pkg::STATUS_DROP;
            end else begin
               slot[idx][tail[idx]] = h;
               tail[idx] = (tail[idx] + 1) % QUEUE_DEPTH;
               fill[idx]++;
               r.status = spq_pkg::STATUS_ENQ;
            end
         end else begin
            for (int c = int'(spq_pkg::CLS_VERY_HIGH); c >= int'(spq_pkg::CLS_LOW); c--) begin
               if (r.status == spq_pkg::STATUS_EMPTY && fill[c] > 0) begin
                  r.status = spq_pkg::STATUS_DEQ;
                  r.handle = slot[c][head[c]];
                  r.cls = 2'(c);
                  head[c] = (head[c] + 1) % QUEUE_DEPTH;
                  fill[c]--;
               end
            end
         end
         pending_results.push_back(r);
      endfunction

      function void check_result(logic [1:0] st, logic [spq_pkg::EXT_HANDLE_W-1:0] h,
                                 logic [1:0] c);
         queue_result_type want;
         if (pending_results.size() == 0) begin
            $error("result with nothing pending: status %0d handle %h class %0d", st, h, c);
            failures++;
            return;
         end
         want = pending_results.pop_front();
         status_seen[st]++;
         if (st !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, st);
            failures++;
         end
         if (h !== want.handle) begin
            $error("out_handle: expected %h, actual %h", want.handle, h);
            failures++;
         end
         if (c !== want.cls) begin
            $error("out_class: expected %0d, actual %0d", want.cls, c);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic req_func;
   logic [spq_pkg::EXT_HANDLE_W-1:0] req_packet_handle;
   logic req_very_high_flag;
   logic req_high_flag;
   logic csr_wr_en;
   logic [spq_pkg::LIMIT_W-1:0] csr_wr_data;
   logic rsp_valid;
   logic [1:0] rsp_status;
   logic [spq_pkg::EXT_HANDLE_W-1:0] rsp_out_handle;
   logic [1:0] rsp_out_class;

   queue_scoreboard sb;
   int limits_used;

   strict_priority_queue_three_class i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_packet_handle  (req_packet_handle),
      .req_very_high_flag (req_very_high_flag),
      .req_high_flag      (req_high_flag),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_out_handle     (rsp_out_handle),
      .rsp_out_class      (rsp_out_class)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_result(rsp_status, rsp_out_handle, rsp_out_class);
      end
   end

   task automatic send_item(logic func, logic [spq_pkg::EXT_HANDLE_W-1:0] h,
                            logic vh, logic hi);
      @(negedge clock);
      start <= 1'b1;
      req_func <= func;
      req_packet_handle <= h;
      req_very_high_flag <= vh;
      req_high_flag <= hi;
      do @(posedge clock); while (busy);
      sb.note_item(func, h, vh, hi);
   endtask

   task automatic hold_off(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic wait_drained();
      hold_off(1);
      while (sb.pending_results.size() != 0) @(posedge clock);
      hold_off(4);
   endtask

   task automatic write_limit(logic [spq_pkg::LIMIT_W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      sb.set_limit(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      limits_used++;
   endtask

   task automatic send_random(int enq_pct, int bias_cls);
      logic func;
      logic vh;
      logic hi;
      int cls_pick;
      func = ($urandom_range(99) < enq_pct) ? spq_pkg::FUNC_ENQ : spq_pkg::FUNC_DEQ;
      cls_pick = ($urandom_range(99) < 60) ? bias_cls : $urandom_range(2);
      vh = (cls_pick == int'(spq_pkg::CLS_VERY_HIGH));
      hi = (cls_pick == int'(spq_pkg::CLS_HIGH)) ? 1'b1 : 1'($urandom);
      if (cls_pick == int'(spq_pkg::CLS_LOW)) hi = 1'b0;
      if ($urandom_range(9) == 0) begin
         vh = 1'($urandom);
         hi = 1'($urandom);
      end
      send_item(func, 16'($urandom), vh, hi);
   endtask

   task automatic run_phase(logic [spq_pkg::LIMIT_W-1:0] value, int count, bit gappy);
      int burst;
      int bias_cls;
      burst = $urandom_range(1, 24);
      bias_cls = $urandom_range(2);
      write_limit(value);
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) begin
            wait_drained();
         end
         send_random((i < count / 2) ? 80 : 30, bias_cls);
         burst--;
         if (burst == 0) begin
            burst = $urandom_range(1, 24);
            if (gappy) hold_off($urandom_range(1, 8));
         end
      end
   endtask

   initial begin
      sb = new();
      limits_used = 0;
      reset = 1'b1;
      start = 1'b0;
      req_func = spq_pkg::FUNC_ENQ;
      req_packet_handle = '0;
      req_very_high_flag = 1'b0;
      req_high_flag = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      hold_off(2);

      send_item(spq_pkg::FUNC_DEQ, 16'h0000, 1'b0, 1'b0);
      send_item(spq_pkg::FUNC_ENQ, 16'h0000, 1'b0, 1'b0);
      send_item(spq_pkg::FUNC_ENQ, 16'hFFFF, 1'b0, 1'b1);
      send_item(spq_pkg::FUNC_ENQ, 16'hAAAA, 1'b1, 1'b0);
      send_item(spq_pkg::FUNC_ENQ, 16'h5555, 1'b1, 1'b1);
      repeat (5) send_item(spq_pkg::FUNC_DEQ, 16'h0000, 1'b0, 1'b0);
      send_item(spq_pkg::FUNC_DEQ, 16'hFFFF, 1'b1, 1'b1);

      write_limit(7'd0);
      send_item(spq_pkg::FUNC_ENQ, 16'h8001, 1'b0, 1'b0);
      send_item(spq_pkg::FUNC_ENQ, 16'h7FFE, 1'b0, 1'b1);
      send_item(spq_pkg::FUNC_ENQ, 16'hFFFF, 1'b1, 1'b1);
      send_item(spq_pkg::FUNC_DEQ, 16'h0000, 1'b0, 1'b0);

      write_limit(7'd1);
      send_item(spq_pkg::FUNC_ENQ, 16'h1234, 1'b0, 1'b0);
      send_item(spq_pkg::FUNC_ENQ, 16'h4321, 1'b0, 1'b0);
      send_item(spq_pkg::FUNC_ENQ, 16'hBEEF, 1'b1, 1'b0);
      send_item(spq_pkg::FUNC_DEQ, 16'h0000, 1'b0, 1'b0);
      send_item(spq_pkg::FUNC_DEQ, 16'h0000, 1'b0, 1'b0);
      send_item(spq_pkg::FUNC_DEQ, 16'h0000, 1'b0, 1'b0);

      run_phase(7'd127, 220, 1'b1);
      run_phase(7'd64, 200, 1'b0);
      run_phase(7'd1, 120, 1'b1);
      run_phase(7'd0, 100, 1'b0);
      run_phase(7'd37, 200, 1'b1);
      run_phase(7'($urandom_range(0, 127)), 180, 1'b0);
      run_phase(7'd127, 200, 1'b1);

      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.pending_results.size() != 0) begin
         $error("%0d results never arrived", sb.pending_results.size());
         sb.failures++;
      end
      $display("Covered %0d items over %0d queue_limit settings", sb.items, limits_used + 1);
      $display("Results: %0d enqueued, %0d dropped, %0d dequeued, %0d empty",
               sb.status_seen[spq_pkg::STATUS_ENQ], sb.status_seen[spq_pkg::STATUS_DROP],
               sb.status_seen[spq_pkg::STATUS_DEQ], sb.status_seen[spq_pkg::STATUS_EMPTY]);
      if (sb.failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
